// ===== rtl/core/char_lcd_nibble_driver_macros.svh =====
// Assertion macros shared by the character display driver.
`ifndef CHAR_LCD_NIBBLE_DRIVER_MACROS_SVH
`define CHAR_LCD_NIBBLE_DRIVER_MACROS_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define CLND_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define CLND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/clnd_pkg.sv =====
// Types and constants of the character display driver.
package clnd_pkg;

  typedef enum logic [3:0] {
    CMD_CHAR     = 4'd0,
    CMD_RAW      = 4'd1,
    CMD_POSITION = 4'd2,
    CMD_HOME     = 4'd3,
    CMD_CLEAR    = 4'd4,
    CMD_DISPLAY  = 4'd5,
    CMD_CURSOR   = 4'd6,
    CMD_BLINK    = 4'd7,
    CMD_INIT     = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_INSTR = 3'd1,
    KIND_HOME  = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_INIT  = 3'd4
  } kind_e;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_e;

  localparam logic [7:0] INSTR_CLEAR     = 8'h01;
  localparam logic [7:0] INSTR_HOME      = 8'h02;
  localparam logic [7:0] INSTR_ENTRY     = 8'h06;
  localparam logic [7:0] INSTR_CONTROL   = 8'h08;
  localparam logic [7:0] INSTR_CTRL_INIT = 8'h0C;
  localparam logic [7:0] INSTR_SHIFT     = 8'h14;
  localparam logic [7:0] INSTR_FUNC_2L   = 8'h28;
  localparam logic [7:0] INSTR_ADDR      = 8'h80;
  localparam logic [7:0] ADDR_ROW_OFFSET = 8'h40;
  localparam logic [7:0] NIBBLE_MASK     = 8'h0F;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;

  localparam logic [2:0] CTRL_DISPLAY = 3'b100;
  localparam logic [2:0] CTRL_CURSOR  = 3'b010;
  localparam logic [2:0] CTRL_BLINK   = 3'b001;

  localparam logic [15:0] WAIT_NONE  = 16'd0;
  localparam logic [15:0] WAIT_INSTR = 16'd2000;
  localparam logic [15:0] WAIT_HOME  = 16'd7000;
  localparam logic [15:0] WAIT_INIT  = 16'd35000;
  localparam logic [15:0] WAIT_FUNC  = 16'd37000;

  localparam logic [5:0] RESET_COLUMNS = 6'd16;
  localparam logic [1:0] RESET_ROWS    = 2'd2;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] data_byte;
    logic [5:0] col_x;
    logic [2:0] row_y;
    logic       flag_on;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       flag;
  } job_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  bus_nibble;
    logic [15:0] wait_after_us;
    logic        last;
  } xfer_t;

  typedef struct packed {
    logic [5:0] col;
    logic [1:0] row;
    logic [2:0] ctrl;
  } state_t;

  typedef struct packed {
    logic busy;
    logic in_ready;
  } seq_status_t;

endpackage

// ===== rtl/core/clnd_cmd_if.sv =====
// Command channel: one display command per transaction.
interface clnd_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [7:0] data_byte;
  logic [5:0] col_x;
  logic [2:0] row_y;
  logic       flag_on;

  modport source (output valid, command, data_byte, col_x, row_y, flag_on, input ready);
  modport sink   (input valid, command, data_byte, col_x, row_y, flag_on, output ready);
endinterface

// ===== rtl/core/clnd_xfer_if.sv =====
// Transfer channel: one nibble transfer on the display bus per transaction.
interface clnd_xfer_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  bus_nibble;
  logic [15:0] wait_after_us;
  logic        last;

  modport source (output valid, reg_select, bus_nibble, wait_after_us, last, input ready);
  modport sink   (input valid, reg_select, bus_nibble, wait_after_us, last, output ready);
endinterface

// ===== rtl/core/clnd_decode.sv =====
// Command decoder holding the cursor position and display control bits.
module clnd_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  clnd_pkg::cmd_t  cmd_i,
  input  logic [5:0]      cols_i,
  input  logic [1:0]      rows_i,
  output clnd_pkg::job_t  job_o,
  output logic            job_valid_o,
  output clnd_pkg::state_t state_o
);
  import clnd_pkg::*;

  state_t     state_q, state_d;
  logic [6:0] next_col;
  logic [2:0] next_row;
  logic       col_wrap;
  logic [1:0] wrap_row;
  logic [2:0] ctrl_set;
  logic [2:0] ctrl_new;
  logic [2:0] ctrl_init;

  assign next_col  = {1'b0, state_q.col} + 7'd1;
  assign col_wrap  = next_col >= {1'b0, cols_i};
  assign next_row  = {1'b0, state_q.row} + 3'd1;
  assign wrap_row  = (next_row >= {1'b0, rows_i}) ? 2'd0 : next_row[1:0];
  assign ctrl_init = state_q.ctrl | CTRL_DISPLAY;

  always_comb begin
    ctrl_set = CTRL_BLINK;
    case (cmd_i.command)
      CMD_DISPLAY: ctrl_set = CTRL_DISPLAY;
      CMD_CURSOR:  ctrl_set = CTRL_CURSOR;
      default:     ctrl_set = CTRL_BLINK;
    endcase
    ctrl_new = cmd_i.flag_on ? (state_q.ctrl | ctrl_set) : (state_q.ctrl & ~ctrl_set);
  end

  always_comb begin
    state_d     = state_q;
    job_valid_o = 1'b1;
    job_o.kind  = KIND_INSTR;
    job_o.byte0 = cmd_i.data_byte;
    job_o.byte1 = INSTR_ADDR;
    job_o.flag  = 1'b0;
    case (cmd_i.command)
      CMD_CHAR: begin
        job_o.kind = KIND_CHAR;
        job_o.flag = col_wrap;
        job_o.byte1 = (wrap_row != 2'd0) ? (INSTR_ADDR | ADDR_ROW_OFFSET) : INSTR_ADDR;
        if (col_wrap) begin
          state_d.col = 6'd0;
          state_d.row = wrap_row;
        end else begin
          state_d.col = next_col[5:0];
        end
      end
      CMD_RAW: begin
        job_o.kind = KIND_INSTR;
      end
      CMD_POSITION: begin
        if ((cmd_i.col_x > cols_i) || (cmd_i.row_y > {1'b0, rows_i})) begin
          job_valid_o = 1'b0;
        end else begin
          job_o.byte0 = {2'b00, cmd_i.col_x}
                      + ((cmd_i.row_y != 3'd0) ? (INSTR_ADDR | ADDR_ROW_OFFSET) : INSTR_ADDR);
          state_d.col = cmd_i.col_x;
          state_d.row = cmd_i.row_y[1:0];
        end
      end
      CMD_HOME: begin
        job_o.kind  = KIND_HOME;
        state_d.col = 6'd0;
        state_d.row = 2'd0;
      end
      CMD_CLEAR: begin
        job_o.kind  = KIND_CLEAR;
        state_d.col = 6'd0;
        state_d.row = 2'd0;
      end
      CMD_DISPLAY, CMD_CURSOR, CMD_BLINK: begin
        job_o.byte0  = INSTR_CONTROL | {5'd0, ctrl_new};
        state_d.ctrl = ctrl_new;
      end
      CMD_INIT: begin
        job_o.kind   = KIND_INIT;
        job_o.flag   = rows_i > 2'd1;
        job_o.byte0  = INSTR_CONTROL | {5'd0, ctrl_init};
        job_o.byte1  = INSTR_CONTROL | {5'd0, ctrl_init & ~CTRL_CURSOR};
        state_d.col  = 6'd0;
        state_d.row  = 2'd0;
        state_d.ctrl = CTRL_DISPLAY;
      end
      default: begin
        job_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// ===== rtl/core/clnd_seq.sv =====
// Transfer sequencer: walks one decoded command into nibble transfers.
module clnd_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  clnd_pkg::job_t         job_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output clnd_pkg::xfer_t        xfer_o,
  output clnd_pkg::seq_status_t  status_o
);
  import clnd_pkg::*;

  function automatic xfer_t gen_xfer(job_t j, logic [4:0] s);
    logic [7:0]  b;
    logic        rs;
    logic [15:0] w;
    logic        lst;
    logic [4:0]  e;
    xfer_t       x;
    b   = j.byte0;
    rs  = 1'b0;
    w   = WAIT_INSTR;
    lst = (s == 5'd1);
    e   = s;
    case (j.kind)
      KIND_CHAR: begin
        rs  = !s[1];
        b   = s[1] ? j.byte1 : j.byte0;
        w   = s[1] ? WAIT_INSTR : WAIT_NONE;
        lst = (s == 5'd3) || ((s == 5'd1) && !j.flag);
      end
      KIND_INSTR: begin
        b = j.byte0;
      end
      KIND_HOME: begin
        b = INSTR_HOME;
        w = WAIT_HOME;
      end
      KIND_CLEAR: begin
        b   = s[1] ? INSTR_HOME : INSTR_CLEAR;
        w   = s[1] ? WAIT_HOME : WAIT_INSTR;
        lst = (s == 5'd3);
      end
      KIND_INIT: begin
        // Without the two-line function set, the sequence skips its two nibbles.
        e   = (!j.flag && (s >= 5'd4)) ? s + 5'd2 : s;
        lst = (e == 5'd19);
        case (e[4:1])
          4'd2: begin
            b = INSTR_FUNC_2L;
            w = WAIT_FUNC;
          end
          4'd3: b = j.byte0;
          4'd4: b = j.byte1;
          4'd5: b = INSTR_CTRL_INIT;
          4'd6: b = INSTR_CLEAR;
          4'd7: begin
            b = INSTR_HOME;
            w = WAIT_HOME;
          end
          4'd8: b = INSTR_ENTRY;
          4'd9: b = INSTR_SHIFT;
          default: b = INSTR_CLEAR;
        endcase
      end
      default: begin
        b = j.byte0;
      end
    endcase
    x.reg_select    = rs;
    x.bus_nibble    = e[0] ? b[3:0] : b[7:4];
    x.wait_after_us = e[0] ? w : WAIT_NONE;
    x.last          = lst;
    if ((j.kind == KIND_INIT) && (e < 5'd4)) begin
      x.bus_nibble    = (e == 5'd3) ? NIB_4BIT : NIB_WAKE;
      x.wait_after_us = WAIT_INIT;
    end
    return x;
  endfunction

  job_t       job_q;
  logic       job_valid_q;
  logic [4:0] step_q;
  logic       out_valid_q;
  xfer_t      out_q;
  xfer_t      cur;
  logic       out_adv;
  logic       emit;
  logic       done;

  assign cur     = gen_xfer(job_q, step_q);
  assign out_adv = !out_valid_q || out_ready_i;
  assign emit    = job_valid_q && out_adv;
  assign done    = emit && cur.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      step_q      <= 5'd0;
      out_valid_q <= 1'b0;
      job_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_adv) begin
        out_valid_q <= job_valid_q;
      end
      if (emit) begin
        out_q <= cur;
      end
      if (load_i) begin
        job_valid_q <= 1'b1;
        step_q      <= 5'd0;
        job_q       <= job_i;
      end else if (done) begin
        job_valid_q <= 1'b0;
      end else if (emit) begin
        step_q <= step_q + 5'd1;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign xfer_o            = out_q;
  assign status_o.busy     = job_valid_q;
  assign status_o.in_ready = !job_valid_q || done;

endmodule

// ===== rtl/core/char_lcd_nibble_driver.sv =====
// Top level of the 4-bit character display driver with its register port.
//
// Each command transaction produces between zero and twenty nibble transfers,
// issued at one transfer per clock while the transfer channel takes them; a
// character produces two or four, an instruction, home or position two, a
// clear four and the power-up sequence eighteen or twenty. Commands reach the
// bus through the sequencer's job and output registers, and the next command
// is taken in the cycle that issues the last transfer of the current one, so
// the rate is set by the single transfer sequencer. Cursor tracking and the
// display control bits are updated when a command is taken; position commands
// past the configured column or row count and unknown commands yield nothing.
// Registers: display_columns at byte address 0, display_rows at address 4.
module char_lcd_nibble_driver (
  input  logic        clk_i,
  input  logic        rst_ni,
  clnd_cmd_if.sink    cmd_i,
  clnd_xfer_if.source xfer_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import clnd_pkg::*;

  `include "char_lcd_nibble_driver_macros.svh"

  logic [5:0]  cols_q;
  logic [1:0]  rows_q;
  logic        cfg_write;
  reg_e        cfg_reg;
  cmd_t        cmd;
  logic        cmd_fire;
  job_t        dec_job;
  logic        dec_job_valid;
  state_t      dec_state;
  xfer_t       seq_xfer;
  seq_status_t seq_status;

  assign pready    = 1'b1;
  assign cfg_reg   = reg_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= RESET_COLUMNS;
      rows_q <= RESET_ROWS;
    end else if (cfg_write) begin
      case (cfg_reg)
        REG_COLUMNS: cols_q <= pwdata[5:0];
        REG_ROWS:    rows_q <= pwdata[1:0];
        default:     cols_q <= cols_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_COLUMNS: prdata = {26'd0, cols_q};
      REG_ROWS:    prdata = {30'd0, rows_q};
      default:     prdata = 32'd0;
    endcase
  end

  assign cmd.command   = cmd_i.command;
  assign cmd.data_byte = cmd_i.data_byte;
  assign cmd.col_x     = cmd_i.col_x;
  assign cmd.row_y     = cmd_i.row_y;
  assign cmd.flag_on   = cmd_i.flag_on;
  assign cmd_i.ready   = seq_status.in_ready;
  assign cmd_fire      = cmd_i.valid && cmd_i.ready;

  clnd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (cmd_fire),
    .cmd_i       (cmd),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .job_o       (dec_job),
    .job_valid_o (dec_job_valid),
    .state_o     (dec_state)
  );

  clnd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (cmd_fire && dec_job_valid),
    .job_i       (dec_job),
    .out_ready_i (xfer_o.ready),
    .out_valid_o (xfer_o.valid),
    .xfer_o      (seq_xfer),
    .status_o    (seq_status)
  );

  assign xfer_o.reg_select    = seq_xfer.reg_select;
  assign xfer_o.bus_nibble    = seq_xfer.bus_nibble;
  assign xfer_o.wait_after_us = seq_xfer.wait_after_us;
  assign xfer_o.last          = seq_xfer.last;

  `CLND_ASSERT_NEXT(a_load_starts_job, cmd_fire && dec_job_valid, seq_status.busy,
                    "Accepted command with transfers did not start the sequencer.")
  `CLND_ASSERT_IMPL(a_ready_only_at_end, seq_status.busy && cmd_i.ready,
                    !xfer_o.valid || xfer_o.ready,
                    "Command taken while the sequencer could not finish its job.")
  `CLND_ASSERT_NEXT(a_init_control, cmd_fire && (cmd_i.command == CMD_INIT),
                    (dec_state.ctrl == CTRL_DISPLAY) && (dec_state.col == 6'd0)
                    && (dec_state.row == 2'd0),
                    "Init did not leave the display on with the cursor at home.")

endmodule
